// ===== hdl/tspc_pkg.sv =====
// Shared types, codes and helper functions for the tile/sprite pixel compositor.
// No dependencies; imported by the top level, tspc_front and tspc_back.
package tspc_pkg;

	localparam int VRAM_AW    = 13;
	localparam int QDEPTH     = 4;
	localparam int QAW        = 2;

	// input opcodes as they arrive on tuser
	localparam logic [1:0] OP_VRAM_WR = 2'd0;
	localparam logic [1:0] OP_SPR_WR  = 2'd1;
	localparam logic [1:0] OP_RENDER  = 2'd2;
	localparam logic [1:0] OP_UNUSED  = 2'd3;

	// configuration register indexes
	localparam logic [7:0] REG_LCD  = 8'd0;
	localparam logic [7:0] REG_SCX  = 8'd1;
	localparam logic [7:0] REG_SCY  = 8'd2;
	localparam logic [7:0] REG_WX   = 8'd3;
	localparam logic [7:0] REG_WY   = 8'd4;
	localparam logic [7:0] REG_BGP  = 8'd5;
	localparam logic [7:0] REG_OBP0 = 8'd6;
	localparam logic [7:0] REG_OBP1 = 8'd7;

	// lcd_control bits
	localparam int LCD_BG_ON   = 0;
	localparam int LCD_SPR_ON  = 1;
	localparam int LCD_BG_MAP  = 3;
	localparam int LCD_DATA_LO = 4;
	localparam int LCD_WIN_ON  = 5;
	localparam int LCD_WIN_MAP = 6;

	typedef enum logic [1:0] {
		KIND_VRAM_WR,
		KIND_SPR_WR,
		KIND_RENDER
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [12:0] addr;
		logic [7:0]  data;
		logic [7:0]  x;
		logic [7:0]  y;
	} item_t;

	typedef struct packed {
		logic [7:0] lcd;
		logic [7:0] scx;
		logic [7:0] scy;
		logic [7:0] wx;
		logic [7:0] wy;
		logic [7:0] bgp;
		logic [7:0] obp0;
		logic [7:0] obp1;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MAP,
		ST_TILE,
		ST_BGID,
		ST_SCAN,
		ST_SPR,
		ST_OUT
	} state_t;

	function automatic logic [7:0] gray_of(input logic [7:0] pal, input logic [1:0] id);
		logic [1:0] shade;
		logic [7:0] g;
		shade = 2'(pal >> {id, 1'b0});
		case (shade)
			2'd0:    g = 8'hFF;
			2'd1:    g = 8'hAA;
			2'd2:    g = 8'h55;
			default: g = 8'h00;
		endcase
		return g;
	endfunction

	// low-plane byte of one tile row for background/window tiles
	function automatic logic [12:0] bg_row_addr(input logic [7:0] t, input logic [2:0] row,
			input logic unsigned_mode);
		logic [12:0] base;
		if (unsigned_mode)
			base = {1'b0, t, 4'h0};
		else
			base = 13'h0800 + {1'b0, t ^ 8'h80, 4'h0};
		return base | {9'd0, row, 1'b0};
	endfunction

endpackage

// ===== hdl/tile_sprite_pixel_compositor.sv =====
// Top level of the tile/sprite pixel compositor: config registers, front end and engine.
// Depends on tspc_pkg, tspc_front and tspc_back.
//
// Use: words on the s_axis channel either store a byte (video memory or sprite
// table) or request one pixel; each pixel request gives one word on m_axis with
// the gray level in tdata and a sprite flag in tuser. Registers are written over
// the cfg channel (always ready); the user must write them only while no item is in
// flight, as the block does not enforce this.
// Sequence: a store is written when the engine takes it from the queue; a pixel
// request passes the map, tile and background-id steps, then a scan and a sprite
// step for each sprite whose 8x8 box covers the pixel, lowest index first, until one
// shows a nonzero color there, then the output step. The engine handles one item at a
// time; two video memory read ports feed each tile or sprite row fetch.
// A four-word queue sits in front, so input keeps flowing while the engine works.
// Reset: registers take their defaults and a clearing pass writes zeros through
// all 8192 video memory bytes, one per cycle, with s_axis_tready low meanwhile.
// When the receiver stalls, the result waits in the output register and the
// engine holds; the queue then fills and tready drops.
module tile_sprite_pixel_compositor #(
	parameter int NUM_SPRITES = 40
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // mem_address[12:0], mem_data[20:13], pixel_x[28:21], pixel_y[36:29]
	input  logic [1:0]  s_axis_tuser,  // opcode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // pixel_gray
	output logic        m_axis_tuser,  // from_sprite
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [7:0]  cfg_data
);
	import tspc_pkg::*;

	cfg_t  cfg_q;
	logic  accept_en;
	logic  q_valid, q_pop;
	item_t q_item;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lcd  <= 8'h91;
			cfg_q.scx  <= 8'h00;
			cfg_q.scy  <= 8'h00;
			cfg_q.wx   <= 8'h07;
			cfg_q.wy   <= 8'h00;
			cfg_q.bgp  <= 8'hFC;
			cfg_q.obp0 <= 8'hFF;
			cfg_q.obp1 <= 8'hFF;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_LCD:  cfg_q.lcd  <= cfg_data;
				REG_SCX:  cfg_q.scx  <= cfg_data;
				REG_SCY:  cfg_q.scy  <= cfg_data;
				REG_WX:   cfg_q.wx   <= cfg_data;
				REG_WY:   cfg_q.wy   <= cfg_data;
				REG_BGP:  cfg_q.bgp  <= cfg_data;
				REG_OBP0: cfg_q.obp0 <= cfg_data;
				REG_OBP1: cfg_q.obp1 <= cfg_data;
				default:  ;
			endcase
		end
	end

	tspc_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.accept_en     (accept_en),
		.q_valid       (q_valid),
		.q_item        (q_item),
		.q_pop         (q_pop)
	);

	tspc_back #(.NUM_SPRITES(NUM_SPRITES)) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.q_valid       (q_valid),
		.q_item        (q_item),
		.q_pop         (q_pop),
		.accept_en     (accept_en),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule

// ===== hdl/tspc_front.sv =====
// Front end: accepts input words, classifies them and queues them for the engine.
// Depends on tspc_pkg.
module tspc_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [39:0]       s_axis_tdata,  // mem_address[12:0], mem_data, pixel_x, pixel_y, pad
	input  logic [1:0]        s_axis_tuser,  // opcode
	input  logic              accept_en,
	output logic              q_valid,
	output tspc_pkg::item_t   q_item,
	input  logic              q_pop
);
	import tspc_pkg::*;

	item_t          fifo_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QAW:0]   cnt_q;
	logic           keep;
	logic           push;
	item_t          in_item;

	always_comb begin
		keep = 1'b1;
		in_item.kind = KIND_RENDER;
		unique case (s_axis_tuser)
			OP_VRAM_WR: in_item.kind = KIND_VRAM_WR;
			OP_SPR_WR:  in_item.kind = KIND_SPR_WR;
			OP_RENDER:  in_item.kind = KIND_RENDER;
			default:    keep = 1'b0;  // unused opcode: dropped
		endcase
		in_item.addr = s_axis_tdata[12:0];
		in_item.data = s_axis_tdata[20:13];
		in_item.x    = s_axis_tdata[28:21];
		in_item.y    = s_axis_tdata[36:29];
	end

	assign s_axis_tready = accept_en && (cnt_q != (QAW+1)'(QDEPTH));
	assign push    = s_axis_tvalid && s_axis_tready && keep;
	assign q_valid = (cnt_q != '0);
	assign q_item  = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			fifo_q[wr_ptr_q] <= in_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (q_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			cnt_q <= cnt_q + (QAW+1)'(push) - (QAW+1)'(q_pop);
		end
	end

endmodule

// ===== hdl/tspc_back.sv =====
// Back end: video memory, sprite table and the render sequencer with its output register.
// Depends on tspc_pkg; fed by tspc_front.
module tspc_back #(
	parameter int NUM_SPRITES = 40
) (
	input  logic             clk,
	input  logic             arst_n,
	input  tspc_pkg::cfg_t   cfg,
	input  logic             q_valid,
	input  tspc_pkg::item_t  q_item,
	output logic             q_pop,
	output logic             accept_en,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [7:0]       m_axis_tdata,
	output logic             m_axis_tuser
);
	import tspc_pkg::*;

	localparam int SIW = (NUM_SPRITES > 1) ? $clog2(NUM_SPRITES) : 1;

	state_t state_q, state_nx;

	logic [7:0]  vram [2**VRAM_AW];
	logic [7:0]  rd_a_q, rd_b_q;
	logic [12:0] rd_a_addr, rd_b_addr;
	logic        wr_en;
	logic [12:0] wr_addr;
	logic [7:0]  wr_data;
	logic [12:0] clr_cnt_q;

	logic [7:0]  spr_q [NUM_SPRITES][4];

	logic [7:0]  x_q, y_q;
	logic        win_q, layer_on_q;
	logic [2:0]  row_q, bit_q;
	logic [1:0]  id_q;
	logic [NUM_SPRITES-1:0] mask_q, hit;
	logic [2:0]  sbit_q;
	logic        spal_q;
	logic [7:0]  res_gray_q;
	logic        res_spr_q;
	logic        m_valid_q;
	logic [7:0]  m_gray_q;
	logic        m_spr_q;

	// background / window coordinates
	logic [7:0]  bx, by, wxc, wyr, tsel;
	logic        win_on;
	logic [12:0] row_fetch_addr;

	// sprite scan
	logic [SIW-1:0] idx;
	logic [9:0]  sv_y, sv_x;
	logic [2:0]  sdy;
	logic [1:0]  sid;
	logic        out_free;

	assign bx     = x_q + cfg.scx;
	assign by     = y_q + cfg.scy;
	assign wxc    = x_q + 8'd7 - cfg.wx;
	assign wyr    = y_q - cfg.wy;
	assign win_on = cfg.lcd[LCD_WIN_ON] && (y_q >= cfg.wy)
		&& (({1'b0, x_q} + 9'd7) >= {1'b0, cfg.wx});
	assign tsel           = win_q ? rd_b_q : rd_a_q;
	assign row_fetch_addr = bg_row_addr(tsel, row_q, cfg.lcd[LCD_DATA_LO]);
	assign out_free  = !m_valid_q || m_axis_tready;
	assign accept_en = (state_q != ST_CLEAR);

	// one box test per sprite
	for (genvar i = 0; i < NUM_SPRITES; i++) begin : g_lane
		logic [9:0] vy, vx;
		assign vy = {2'b0, y_q} + 10'd16 - {2'b0, spr_q[i][0]};
		assign vx = {2'b0, x_q} + 10'd8  - {2'b0, spr_q[i][1]};
		assign hit[i] = (vy[9:3] == '0) && (vx[9:3] == '0);
	end

	// first pending sprite, lowest index wins
	always_comb begin
		idx = '0;
		for (int i = NUM_SPRITES - 1; i >= 0; i--)
			if (mask_q[i])
				idx = SIW'(i);
	end

	assign sv_y = {2'b0, y_q} + 10'd16 - {2'b0, spr_q[idx][0]};
	assign sv_x = {2'b0, x_q} + 10'd8  - {2'b0, spr_q[idx][1]};
	assign sdy  = sv_y[2:0] ^ {3{spr_q[idx][3][6]}};
	assign sid  = {rd_b_q[sbit_q], rd_a_q[sbit_q]};

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_CLEAR: if (clr_cnt_q == '1) state_nx = ST_IDLE;
			ST_IDLE:  if (q_valid && q_item.kind == KIND_RENDER) state_nx = ST_MAP;
			ST_MAP:   state_nx = ST_TILE;
			ST_TILE:  state_nx = ST_BGID;
			ST_BGID:  state_nx = ST_SCAN;
			ST_SCAN:  state_nx = (mask_q == '0) ? ST_OUT : ST_SPR;
			ST_SPR:   state_nx = (sid != 2'd0) ? ST_OUT : ST_SCAN;
			ST_OUT:   if (out_free) state_nx = ST_IDLE;
			default:  state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		q_pop     = 1'b0;
		wr_en     = 1'b0;
		wr_addr   = q_item.addr;
		wr_data   = q_item.data;
		rd_a_addr = row_fetch_addr;
		rd_b_addr = row_fetch_addr | 13'd1;
		unique case (state_q)
			ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_cnt_q;
				wr_data = 8'h00;
			end
			ST_IDLE: begin
				q_pop = q_valid;
				wr_en = q_valid && (q_item.kind == KIND_VRAM_WR);
			end
			ST_MAP: begin
				rd_a_addr = {2'b11, cfg.lcd[LCD_BG_MAP], by[7:3], bx[7:3]};
				rd_b_addr = {2'b11, cfg.lcd[LCD_WIN_MAP], wyr[7:3], wxc[7:3]};
			end
			ST_SCAN: begin
				rd_a_addr = {1'b0, spr_q[idx][2], sdy, 1'b0};
				rd_b_addr = {1'b0, spr_q[idx][2], sdy, 1'b1};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			vram[wr_addr] <= wr_data;
		rd_a_q <= vram[rd_a_addr];
		rd_b_q <= vram[rd_b_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SPRITES; i++)
				for (int j = 0; j < 4; j++)
					spr_q[i][j] <= 8'h00;
		end else if (q_pop && q_item.kind == KIND_SPR_WR
				&& q_item.addr[12:2] < 11'(NUM_SPRITES)) begin
			spr_q[q_item.addr[SIW+1:2]][q_item.addr[1:0]] <= q_item.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_cnt_q <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == ST_CLEAR)
				clr_cnt_q <= clr_cnt_q + 13'd1;
			if (state_q == ST_OUT && out_free)
				m_valid_q <= 1'b1;
			else if (m_axis_tready)
				m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				x_q <= q_item.x;
				y_q <= q_item.y;
			end
			ST_MAP: begin
				win_q      <= win_on;
				layer_on_q <= win_on || cfg.lcd[LCD_BG_ON];
				row_q      <= win_on ? wyr[2:0] : by[2:0];
				bit_q      <= win_on ? ~wxc[2:0] : ~bx[2:0];
				mask_q     <= hit & {NUM_SPRITES{cfg.lcd[LCD_SPR_ON]}};
			end
			ST_BGID: id_q <= layer_on_q ? {rd_b_q[bit_q], rd_a_q[bit_q]} : 2'd0;
			ST_SCAN: begin
				sbit_q <= sv_x[2:0] ^ {3{~spr_q[idx][3][5]}};
				spal_q <= spr_q[idx][3][4];
				mask_q[idx] <= 1'b0;
				res_gray_q  <= gray_of(cfg.bgp, id_q);
				res_spr_q   <= 1'b0;
			end
			ST_SPR: begin
				if (sid != 2'd0) begin
					res_gray_q <= gray_of(spal_q ? cfg.obp1 : cfg.obp0, sid);
					res_spr_q  <= 1'b1;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					m_gray_q <= res_gray_q;
					m_spr_q  <= res_spr_q;
				end
			end
			default: ;
		endcase
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_gray_q;
	assign m_axis_tuser  = m_spr_q;

endmodule

// ===== hdl/tspc_checker.sv =====
// Port-level checks for the tile/sprite pixel compositor, bound to the top level.
// Depends only on the top level's ports.
module tspc_port_checks (
	input logic       clk,
	input logic       arst_n,
	input logic       s_axis_tready,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata,
	input logic       cfg_ready
);

	// gray output only takes the four shade levels
	a_gray_levels: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata == 8'hFF || m_axis_tdata == 8'hAA
			|| m_axis_tdata == 8'h55 || m_axis_tdata == 8'h00))
		else $error("gray level outside shade set");

	// memory clear pass keeps input closed right after reset
	a_clear_after_reset: assert property (@(posedge clk)
		!arst_n |=> !s_axis_tready)
		else $error("input ready during clear pass");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("config channel not ready");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled output word changed");

endmodule

bind tile_sprite_pixel_compositor tspc_port_checks u_tspc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.cfg_ready     (cfg_ready)
);

// ===== test/tspc_checker.sv =====
// Checker for the tile/sprite pixel compositor: mirrors config writes, stores and
// renders seen on the channels, predicts each pixel word and compares. Uses tspc_pkg.
module tspc_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,
	input  logic [1:0]  s_axis_tuser,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [7:0]  m_axis_tdata,
	input  logic        m_axis_tuser,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	output int          errors,
	output int          pending
);
	import tspc_pkg::*;

	typedef struct packed {
		logic [7:0] gray;
		logic       spr;
	} pixel_t;

	logic [7:0] vmem [0:8191];
	logic [7:0] oam [0:159];
	logic [7:0] regs [0:7];
	pixel_t expected_pixels [$];

	function automatic logic [1:0] tile_id(input logic [12:0] base, input int row,
			input int bitpos);
		logic [7:0] lo;
		logic [7:0] hi;
		lo = vmem[13'(base + row * 2)];
		hi = vmem[13'(base + row * 2 + 1)];
		return {hi[bitpos & 7], lo[bitpos & 7]};
	endfunction

	function automatic logic [12:0] layer_base(input logic [7:0] t);
		if (regs[REG_LCD][LCD_DATA_LO])
			return {1'b0, t, 4'h0};
		return 13'h0800 + 13'(((t ^ 8'h80)) * 16);
	endfunction

	function automatic logic [7:0] shade_gray(input logic [7:0] pal, input logic [1:0] id);
		logic [1:0] s;
		s = pal[id * 2 +: 2];
		return 8'(255 - s * 85);
	endfunction

	function automatic pixel_t compose_pixel(input int x, input int y);
		pixel_t r;
		logic [7:0] lcd;
		logic [1:0] id;
		logic [1:0] sid;
		logic [12:0] map;
		logic [7:0] t;
		int bx, by, wx, wy, sx, sy, dx, dy, i;
		lcd = regs[REG_LCD];
		id = 0;
		if (lcd[LCD_BG_ON]) begin
			bx = (x + regs[REG_SCX]) & 255;
			by = (y + regs[REG_SCY]) & 255;
			map = lcd[LCD_BG_MAP] ? 13'h1C00 : 13'h1800;
			t = vmem[13'(map + (by >> 3) * 32 + (bx >> 3))];
			id = tile_id(layer_base(t), by & 7, 7 - (bx & 7));
		end
		if (lcd[LCD_WIN_ON] && y >= regs[REG_WY] && x >= int'(regs[REG_WX]) - 7) begin
			wx = (x - (int'(regs[REG_WX]) - 7)) & 255;
			wy = (y - regs[REG_WY]) & 255;
			map = lcd[LCD_WIN_MAP] ? 13'h1C00 : 13'h1800;
			t = vmem[13'(map + (wy >> 3) * 32 + (wx >> 3))];
			id = tile_id(layer_base(t), wy & 7, 7 - (wx & 7));
		end
		if (lcd[LCD_SPR_ON]) begin
			for (i = 0; i < 40; i++) begin
				sy = int'(oam[i * 4]) - 16;
				sx = int'(oam[i * 4 + 1]) - 8;
				if (x < sx || x >= sx + 8 || y < sy || y >= sy + 8)
					continue;
				dy = y - sy;
				dx = x - sx;
				if (oam[i * 4 + 3][6])
					dy = 7 - dy;
				sid = tile_id({1'b0, oam[i * 4 + 2], 4'h0}, dy,
					oam[i * 4 + 3][5] ? dx : 7 - dx);
				if (sid != 0) begin
					r.gray = shade_gray(oam[i * 4 + 3][4] ? regs[REG_OBP1] : regs[REG_OBP0],
						sid);
					r.spr = 1'b1;
					return r;
				end
			end
		end
		r.gray = shade_gray(regs[REG_BGP], id);
		r.spr = 1'b0;
		return r;
	endfunction

	assign pending = expected_pixels.size();

	always @(posedge clk or negedge arst_n) begin
		pixel_t want;
		if (!arst_n) begin
			for (int a = 0; a < 8192; a++)
				vmem[a] = 0;
			for (int a = 0; a < 160; a++)
				oam[a] = 0;
			regs[REG_LCD] = 8'h91; regs[REG_SCX] = 0; regs[REG_SCY] = 0; regs[REG_WX] = 7;
			regs[REG_WY] = 0; regs[REG_BGP] = 8'hFC; regs[REG_OBP0] = 8'hFF;
			regs[REG_OBP1] = 8'hFF;
			expected_pixels.delete();
			errors = 0;
		end else begin
			if (cfg_valid && cfg_ready && cfg_index < 8)
				regs[cfg_index[2:0]] = cfg_data;
			if (s_axis_tvalid && s_axis_tready) begin
				case (s_axis_tuser)
					OP_VRAM_WR: vmem[s_axis_tdata[12:0]] = s_axis_tdata[20:13];
					OP_SPR_WR: begin
						if (s_axis_tdata[12:0] < 160)
							oam[s_axis_tdata[7:0]] = s_axis_tdata[20:13];
					end
					OP_RENDER: expected_pixels.push_back(
						compose_pixel(s_axis_tdata[28:21], s_axis_tdata[36:29]));
					default: ;
				endcase
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_pixels.size() == 0) begin
					$display("%0t: unexpected pixel word gray=%h sprite=%b", $time,
						m_axis_tdata, m_axis_tuser);
					errors++;
				end else begin
					want = expected_pixels.pop_front();
					if (want.gray !== m_axis_tdata || want.spr !== m_axis_tuser) begin
						$display("%0t: pixel mismatch expected gray=%h sprite=%b, got gray=%h sprite=%b",
							$time, want.gray, want.spr, m_axis_tdata, m_axis_tuser);
						errors++;
					end
				end
			end
		end
	end
endmodule

// ===== test/tile_sprite_pixel_compositor_test.sv =====
// Stimulus and verdict for the tile/sprite pixel compositor: directed corners, then
// random scenes of tiles, sprites and pixel requests. Uses tspc_pkg and tspc_checker.
module tile_sprite_pixel_compositor_test;
	import tspc_pkg::*;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_axis_tvalid = 0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata = 0;
	logic [1:0]  s_axis_tuser = 0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 0;
	logic [7:0]  m_axis_tdata;
	logic        m_axis_tuser;
	logic        cfg_valid = 0;
	logic        cfg_ready;
	logic [7:0]  cfg_index = 0;
	logic [7:0]  cfg_data = 0;
	int          errors;
	int          pending;
	int          cycles = 0;

	localparam int CYCLE_LIMIT = 1000000;

	always #5 clk = ~clk;

	tile_sprite_pixel_compositor i_dut (.*);

	tspc_checker i_checker (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// receiver: random stall before each word
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			gap = $urandom_range(0, 9);
			if ($urandom_range(0, 3) == 0)
				gap = 0;
			repeat (gap) @(posedge clk);
			m_axis_tready <= 1;
			@(posedge clk);
			while (!m_axis_tvalid)
				@(posedge clk);
			m_axis_tready <= 0;
		end
	end

	task automatic send_word(input logic [1:0] op, input logic [12:0] addr,
			input logic [7:0] data, input logic [7:0] x, input logic [7:0] y, input bit burst);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			s_axis_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tuser <= op;
		s_axis_tdata <= {3'b0, y, x, data, addr};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	task automatic drop_valid;
		s_axis_tvalid <= 0;
		@(posedge clk);
	endtask

	task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 0;
	endtask

	task automatic drain;
		while (pending != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic render(input bit burst);
		send_word(OP_RENDER, 13'($urandom), 8'($urandom), 8'($urandom_range(0, 167)),
			8'($urandom_range(0, 151)), burst);
	endtask

	initial begin
		int burst;
		logic [12:0] a;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: defaults, then corners of every field
		send_word(OP_RENDER, 0, 0, 0, 0, 0);
		send_word(OP_VRAM_WR, 13'h1FFF, 8'hFF, 8'hFF, 8'hFF, 0);
		send_word(OP_VRAM_WR, 13'h1800, 8'h80, 0, 0, 0);
		send_word(OP_VRAM_WR, 13'h1000, 8'hA5, 0, 0, 0);
		send_word(OP_VRAM_WR, 13'h1001, 8'h3C, 0, 0, 0);
		send_word(OP_VRAM_WR, 13'h0800, 8'hFF, 0, 0, 0);
		send_word(OP_SPR_WR, 0, 8'd16, 0, 0, 0);
		send_word(OP_SPR_WR, 1, 8'd8, 0, 0, 0);
		send_word(OP_SPR_WR, 2, 8'h80, 0, 0, 0);
		send_word(OP_SPR_WR, 3, 8'h70, 0, 0, 0);
		send_word(OP_SPR_WR, 13'd159, 8'hFF, 0, 0, 0);
		send_word(OP_SPR_WR, 13'd160, 8'h55, 0, 0, 0);
		send_word(OP_SPR_WR, 13'h1FFF, 8'h55, 0, 0, 0);
		send_word(OP_UNUSED, 13'h1FFF, 8'hFF, 8'hFF, 8'hFF, 0);
		send_word(OP_RENDER, 0, 0, 0, 0, 0);
		send_word(OP_RENDER, 0, 0, 7, 7, 0);
		send_word(OP_RENDER, 0, 0, 8'd159, 8'd143, 0);
		send_word(OP_RENDER, 13'h1FFF, 8'hFF, 8'hFF, 8'hFF, 0);
		drop_valid();
		drain();

		for (int phase = 0; phase < 12; phase++) begin
			// extremes first, then random settings
			if (phase == 0) begin
				write_reg(REG_LCD, 8'h00); write_reg(REG_SCX, 8'h00);
				write_reg(REG_SCY, 8'h00); write_reg(REG_WX, 8'h00);
				write_reg(REG_WY, 8'h00); write_reg(REG_BGP, 8'h00);
				write_reg(REG_OBP0, 8'h00); write_reg(REG_OBP1, 8'h00);
			end else if (phase == 1) begin
				write_reg(REG_LCD, 8'hFF); write_reg(REG_SCX, 8'hFF);
				write_reg(REG_SCY, 8'hFF); write_reg(REG_WX, 8'hFF);
				write_reg(REG_WY, 8'hFF); write_reg(REG_BGP, 8'hFF);
				write_reg(REG_OBP0, 8'hFF); write_reg(REG_OBP1, 8'hFF);
			end else begin
				write_reg(REG_LCD, 8'($urandom) | 8'h03);
				write_reg(REG_SCX, 8'($urandom)); write_reg(REG_SCY, 8'($urandom));
				write_reg(REG_WX, 8'($urandom_range(0, 170)));
				write_reg(REG_WY, 8'($urandom_range(0, 150)));
				write_reg(REG_BGP, 8'($urandom)); write_reg(REG_OBP0, 8'($urandom));
				write_reg(REG_OBP1, 8'($urandom));
			end
			write_reg(8'd8 + 8'($urandom_range(0, 247)), 8'($urandom));
			for (int n = 0; n < 125; n++) begin
				burst = ($urandom_range(0, 3) == 0);
				case ($urandom_range(0, 9))
					0, 1: begin
						// tile data in either addressing region, or a map entry
						a = ($urandom_range(0, 1)) ? 13'($urandom_range(0, 13'h17FF))
							: 13'($urandom_range(13'h1800, 13'h1FFF));
						send_word(OP_VRAM_WR, a, 8'($urandom), 8'($urandom), 8'($urandom),
							burst);
					end
					2: send_word(OP_SPR_WR, 13'($urandom_range(0, 159)), 8'($urandom),
						8'($urandom), 8'($urandom), burst);
					3: send_word(OP_SPR_WR, 13'($urandom_range(0, 8191)), 8'($urandom),
						8'($urandom), 8'($urandom), burst);
					4: send_word(OP_UNUSED, 13'($urandom), 8'($urandom), 8'($urandom),
						8'($urandom), burst);
					5: send_word(OP_RENDER, 13'($urandom), 8'($urandom), 8'($urandom),
						8'($urandom), burst);
					default: render(burst);
				endcase
			end
			drop_valid();
			drain();
		end

		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule
